[hdl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/wwa_pkg.sv]
package wwa_pkg;

    localparam int RING_DEPTH_DEF = 128;

    localparam logic [15:0] WINDOW_RESET = 16'd120;
    localparam logic [11:0] HALF_TURN    = 12'd1800;
    localparam logic [11:0] FULL_TURN    = 12'd3600;
    localparam logic [11:0] SOUTH_LOW    = 12'd900;
    localparam logic [11:0] SOUTH_HIGH   = 12'd2700;
    localparam logic [7:0]  COUNT_SAT    = 8'd255;

    typedef struct packed {
        logic [31:0] now_seconds;
        logic [15:0] wind_speed;
        logic [11:0] dir_tenths;
    } t_in_item;

    typedef struct packed {
        logic [15:0] speed_average;
        logic [15:0] gust_speed;
        logic [11:0] direction_average;
        logic [7:0]  sample_count;
    } t_out_item;

    typedef struct packed {
        logic [31:0] time_stamp;
        logic [15:0] speed;
        logic [11:0] heading;
    } t_ring_entry;

    typedef enum logic {
        DIV_SPEED,
        DIV_DIRECTION
    } t_div_sel;

    typedef struct packed {
        logic     capture;
        logic     div_start;
        t_div_sel div_sel;
        logic     load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_done;
        logic div_done;
    } t_dp_sts;

endpackage

[hdl/wwa_ctrl.sv]
`include "assert_macros.svh"

module wwa_ctrl
    import wwa_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DIV_SPD,
        S_DIV_DIR,
        S_DONE
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    logic    n_out_valid;
    t_dp_cmd cmd;

    always_comb begin
        cmd         = '0;
        cmd.div_sel = DIV_SPEED;
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.capture = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_SPEED;
                    n_state       = S_DIV_SPD;
                end
            end
            S_DIV_SPD: begin
                if (i_sts.div_done) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_DIRECTION;
                    n_state       = S_DIV_DIR;
                end
            end
            S_DIV_DIR: begin
                if (i_sts.div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold the result until the output register frees up
                if (!r_out_valid || i_out_ready) begin
                    cmd.load_out = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    `ASSERT_IMPLIES(a_div_done_in_div, i_clk, i_rst_n, i_sts.div_done,
        (r_state == S_DIV_SPD) || (r_state == S_DIV_DIR), "division done outside division")
    `ASSERT_IMPLIES(a_no_overwrite, i_clk, i_rst_n, cmd.load_out,
        !r_out_valid || i_out_ready, "result loaded over an untaken transaction")

endmodule

[hdl/wwa_div.sv]
`include "assert_macros.svh"

module wwa_div
    import wwa_pkg::*;
#(
    parameter int NW = 24,
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic [NW-1:0] o_quotient
);

    localparam int SW = $clog2(NW + 1);

    logic [DW-1:0] r_rem;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_dvs;
    logic [SW-1:0] r_step;
    logic          r_busy;
    logic          r_done;

    logic [DW:0]   trial;
    logic          fits;

    // restoring division, one quotient bit per cycle
    assign trial = {r_rem, r_quo[NW-1]};
    assign fits  = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + SW'(1);
                if (r_step == SW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? DW'(trial - {1'b0, r_dvs}) : trial[DW-1:0];
            r_quo <= {r_quo[NW-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    `ASSERT_IMPLIES(a_done_after_busy, i_clk, i_rst_n, r_done,
        $past(r_busy) && !r_busy, "division done without a finished iteration")

endmodule

[hdl/wwa_dp.sv]
`include "assert_macros.svh"

module wwa_dp
    import wwa_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [15:0] i_cfg_data,
    input  t_in_item    i_in_data,
    input  t_dp_cmd     i_cmd,
    output t_dp_sts     o_sts,
    output t_out_item   o_out_data
);

    localparam int AW  = $clog2(RING_DEPTH);
    localparam int CW  = $clog2(RING_DEPTH + 1);
    localparam int SSW = 16 + CW;
    localparam int DSW = 12 + CW;
    localparam int XW  = (CW > 8) ? CW : 8;

    t_ring_entry r_ring [RING_DEPTH];

    logic [15:0]   r_window;
    logic [AW-1:0] r_wslot;
    logic [CW-1:0] r_fill;
    logic [CW-1:0] r_idx;
    logic          r_scan_act;
    logic          r_rd_vld;
    t_ring_entry   r_rd_data;
    logic [31:0]   r_now;

    logic [CW-1:0]  r_count;
    logic [CW-1:0]  r_south;
    logic [SSW-1:0] r_speed_sum;
    logic [DSW-1:0] r_plain_sum;
    logic [DSW-1:0] r_bias_sum;
    logic [15:0]    r_gust;
    logic           r_use_plain;
    t_div_sel       r_sel;
    logic [15:0]    r_spd_avg;
    logic [11:0]    r_dir_avg;
    t_out_item      r_out;

    logic           in_window;
    logic [11:0]    bias;
    logic           is_south;
    logic           use_plain;
    logic [SSW-1:0] dividend;
    logic           div_done;
    logic [SSW-1:0] quotient;
    logic [11:0]    q_dir;
    logic [11:0]    dir_unbias;
    logic [11:0]    dir_pre;
    logic [11:0]    dir_wrap;
    logic [XW-1:0]  count_x;
    logic [7:0]     count_sat;

    // configuration and ring pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window   <= WINDOW_RESET;
            r_wslot    <= '0;
            r_fill     <= '0;
            r_idx      <= '0;
            r_scan_act <= 1'b0;
            r_rd_vld   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_window <= i_cfg_data;
            end
            r_rd_vld <= r_scan_act;
            if (i_cmd.capture) begin
                r_wslot    <= (r_wslot == AW'(RING_DEPTH - 1)) ? '0 : r_wslot + AW'(1);
                r_fill     <= (r_fill == CW'(RING_DEPTH)) ? r_fill : r_fill + CW'(1);
                r_idx      <= '0;
                r_scan_act <= 1'b1;
            end else if (r_scan_act) begin
                r_idx <= r_idx + CW'(1);
                if (r_idx == r_fill - CW'(1)) begin
                    r_scan_act <= 1'b0;
                end
            end
        end
    end

    // ring storage: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ring[r_wslot] <= '{time_stamp: i_in_data.now_seconds,
                                 speed:      i_in_data.wind_speed,
                                 heading:    i_in_data.dir_tenths};
        end
        if (r_scan_act) begin
            r_rd_data <= r_ring[r_idx[AW-1:0]];
        end
    end

    assign in_window = ({1'b0, r_rd_data.time_stamp} + 33'(r_window)) >= {1'b0, r_now};
    assign bias      = (r_rd_data.heading < HALF_TURN) ? r_rd_data.heading + HALF_TURN
                                                       : r_rd_data.heading - HALF_TURN;
    assign is_south  = (r_rd_data.heading > SOUTH_LOW) && (r_rd_data.heading <= SOUTH_HIGH);

    // accumulate every entry inside the window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.capture) begin
            r_count <= '0;
        end else if (r_rd_vld && in_window) begin
            r_count <= r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_now       <= i_in_data.now_seconds;
            r_south     <= '0;
            r_speed_sum <= '0;
            r_plain_sum <= '0;
            r_bias_sum  <= '0;
            r_gust      <= '0;
        end else if (r_rd_vld && in_window) begin
            r_south     <= r_south + CW'(is_south);
            r_speed_sum <= r_speed_sum + SSW'(r_rd_data.speed);
            r_plain_sum <= r_plain_sum + DSW'(r_rd_data.heading);
            r_bias_sum  <= r_bias_sum + DSW'(bias);
            if (r_rd_data.speed > r_gust) begin
                r_gust <= r_rd_data.speed;
            end
        end
    end

    assign use_plain = r_south > (r_count >> 1);
    assign dividend  = (i_cmd.div_sel == DIV_SPEED) ? r_speed_sum
                     : (use_plain ? SSW'(r_plain_sum) : SSW'(r_bias_sum));

    wwa_div #(
        .NW(SSW),
        .DW(CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // undo the half-turn bias unless the plain sum was used, then wrap into one turn
    assign q_dir      = quotient[11:0];
    assign dir_unbias = (q_dir >= HALF_TURN) ? q_dir - HALF_TURN : q_dir + HALF_TURN;
    assign dir_pre    = r_use_plain ? q_dir : dir_unbias;
    assign dir_wrap   = (dir_pre >= FULL_TURN) ? dir_pre - FULL_TURN : dir_pre;

    assign count_x   = XW'(r_count);
    assign count_sat = (count_x > XW'(COUNT_SAT)) ? COUNT_SAT : count_x[7:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_sel <= i_cmd.div_sel;
            if (i_cmd.div_sel == DIV_DIRECTION) begin
                r_use_plain <= use_plain;
            end
        end
        if (div_done) begin
            if (r_sel == DIV_SPEED) begin
                r_spd_avg <= quotient[15:0];
            end else begin
                r_dir_avg <= dir_wrap;
            end
        end
        if (i_cmd.load_out) begin
            r_out <= '{speed_average:     r_spd_avg,
                       gust_speed:        r_gust,
                       direction_average: r_dir_avg,
                       sample_count:      count_sat};
        end
    end

    assign o_sts.scan_done = !r_scan_act && !r_rd_vld;
    assign o_sts.div_done  = div_done;
    assign o_out_data      = r_out;

    `ASSERT_IMPLIES(a_count_le_fill, i_clk, i_rst_n, 1'b1,
        r_count <= r_fill, "window count exceeds filled entries")
    `ASSERT_IMPLIES(a_new_sample_counted, i_clk, i_rst_n,
        i_cmd.div_start && (i_cmd.div_sel == DIV_SPEED),
        r_count != '0, "division started with an empty window")

endmodule

[hdl/wind_window_average_core.sv]
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_ready   i_in_data  (t_in_item)
// result    out        o_out_valid / i_out_ready o_out_data (t_out_item)
// config    in         i_cfg_valid / o_cfg_ready i_cfg_data (window_seconds)
//
// One transaction at a time: capture, a scan over the F filled ring entries, the
// speed division, the direction division, then the load of the output register.
// The scan reads one ring entry a cycle from the single read port of the ring
// memory; the two divisions share one bit-serial divider.
// Reset (synchronous, active low) empties the ring and sets the window to 120 s.
// A result waiting in the output register does not block the next input.
module wind_window_average_core
    import wwa_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    wwa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    wwa_dp #(
        .RING_DEPTH(RING_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_data  (o_out_data)
    );

endmodule
